[design/i2cmrt_pkg.sv]
// shared types and constants for the i2c master register transfer engine
// no dependencies; used by the interfaces and every module of the block

package i2cmrt_pkg;

   // default write buffer depth in bytes
   localparam int MaxBytesDef = 16;

   // bus half period after reset, in ticks
   localparam logic [8:0] HALF_PERIOD_RESET = 9'd5;

   // byte pointer value of the first received data byte
   localparam int RxBase = 3;

   // direction bit of the device address byte
   localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
   localparam logic [7:0] ADDR_READ_BIT   = 8'h01;

   // item kinds
   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2,
      MODE_LOAD  = 2'd3
   } mode_type;

   // bus step sequencer
   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_START_A   = 4'd1,
      PH_START_B   = 4'd2,
      PH_START_C   = 4'd3,
      PH_START_D   = 4'd4,
      PH_TX_LOW    = 4'd5,
      PH_TX_HIGH   = 4'd6,
      PH_ACK_LOW   = 4'd7,
      PH_ACK_HIGH  = 4'd8,
      PH_RX_LOW    = 4'd9,
      PH_RX_HIGH   = 4'd10,
      PH_MACK_LOW  = 4'd11,
      PH_MACK_HIGH = 4'd12,
      PH_STOP_A    = 4'd13,
      PH_STOP_B    = 4'd14,
      PH_STOP_C    = 4'd15
   } phase_type;

   // request transfer payload
   typedef struct packed {
      logic [1:0] mode;
      logic       sda_in;
      logic [7:0] device_addr;
      logic [7:0] register_addr;
      logic [4:0] byte_count;
      logic [7:0] write_byte;
   } req_payload_type;

   // response transfer payload
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       rx_last;
      logic       nack_error;
      logic       done_res;
   } rsp_payload_type;

endpackage

[design/i2cmrt_req_if.sv]
// request channel interface: valid/ready handshake and request payload
// depends on i2cmrt_pkg for the payload type

interface i2cmrt_req_if import i2cmrt_pkg::*; ();

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

[design/i2cmrt_rsp_if.sv]
// response channel interface: valid/ready handshake and response payload
// depends on i2cmrt_pkg for the payload type

interface i2cmrt_rsp_if import i2cmrt_pkg::*; ();

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

[design/i2cmrt_txbuf.sv]
// write data buffer: one write port, one read port, registered read data
// depends on i2cmrt_pkg for the default depth MaxBytesDef

module i2cmrt_txbuf import i2cmrt_pkg::*; #(
   parameter int Depth = MaxBytesDef
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [7:0]                                wr_data,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [7:0]                                rd_data
);

   logic [7:0] mem_ff [Depth];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/i2cmrt_engine.sv]
// bus step sequencer: timing counter, bit and byte pointers, shifter, latches
// depends on i2cmrt_pkg; reads write data from the i2cmrt_txbuf memory

module i2cmrt_engine import i2cmrt_pkg::*; #(
   parameter int MaxBytes = MaxBytesDef
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  req_payload_type        req,
   input  logic [8:0]             half_period,
   input  logic [7:0]             buf_rd_data,
   output logic [((MaxBytes > 1) ? $clog2(MaxBytes) : 1)-1:0] buf_rd_addr,
   output logic                   buf_wr_en,
   output logic [((MaxBytes > 1) ? $clog2(MaxBytes) : 1)-1:0] buf_wr_addr,
   output logic [7:0]             buf_wr_data,
   output rsp_payload_type        rsp
);

   localparam int AddrW = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;
   localparam int CntW  = $clog2(MaxBytes + 1);
   localparam int BiW   = $clog2(MaxBytes + RxBase);

   phase_type        phase_ff, phase_in;
   logic [8:0]       interval_ff, interval_in;
   logic [3:0]       bit_index_ff, bit_index_in;
   logic [BiW-1:0]   byte_index_ff, byte_index_in;
   logic [7:0]       shift_ff, shift_in;
   logic [CntW-1:0]  tx_fill_ff, tx_fill_in;
   logic [7:0]       addr_latch_ff, addr_latch_in;
   logic [7:0]       reg_latch_ff, reg_latch_in;
   logic [CntW-1:0]  count_latch_ff, count_latch_in;
   logic             read_dir_ff, read_dir_in;

   logic             rx_valid, rx_last, nack_err, done;
   logic [7:0]       rx_byte;
   logic [8:0]       hp_eff;
   logic [9:0]       tick_sum;
   logic [BiW-1:0]   data_ptr;

   // last received byte of a read
   function automatic logic is_last(input logic [BiW-1:0] bi, input logic [CntW-1:0] cnt);
      logic ge_base;
      logic ge_cnt;
      ge_base = (bi >= BiW'(RxBase));
      ge_cnt  = ((bi - BiW'(RxBase - 1)) >= BiW'(cnt));
      return ge_base && ge_cnt;
   endfunction

   assign hp_eff   = (half_period == 9'd0) ? 9'd1 : half_period;
   assign tick_sum = {1'b0, interval_ff} + 10'd1;

   // buffer entry of the next data byte; the pointer only moves when a byte
   // starts, so the registered read data has settled long before it is used
   assign data_ptr    = byte_index_ff - BiW'(1);
   assign buf_rd_addr = data_ptr[AddrW-1:0];

   // buffer fill on load items while idle
   assign buf_wr_en   = step_en && (phase_ff == PH_IDLE) && (req.mode == MODE_LOAD)
                        && (tx_fill_ff < CntW'(MaxBytes));
   assign buf_wr_addr = tx_fill_ff[AddrW-1:0];
   assign buf_wr_data = req.write_byte;

   // next state
   always_comb begin
      phase_in       = phase_ff;
      interval_in    = interval_ff;
      bit_index_in   = bit_index_ff;
      byte_index_in  = byte_index_ff;
      shift_in       = shift_ff;
      tx_fill_in     = tx_fill_ff;
      addr_latch_in  = addr_latch_ff;
      reg_latch_in   = reg_latch_ff;
      count_latch_in = count_latch_ff;
      read_dir_in    = read_dir_ff;
      rx_valid       = 1'b0;
      rx_byte        = 8'd0;
      rx_last        = 1'b0;
      nack_err       = 1'b0;
      done           = 1'b0;
      if (step_en) begin
         if (req.mode == MODE_TICK) begin
            if (phase_ff != PH_IDLE) begin
               if (tick_sum >= {1'b0, hp_eff}) begin
                  interval_in = 9'd0;
                  // end of one bus step
                  case (phase_ff)
                     PH_START_A: phase_in = PH_START_B;
                     PH_START_B: phase_in = PH_START_C;
                     PH_START_C: phase_in = PH_START_D;
                     PH_START_D: begin
                        bit_index_in = 4'd0;
                        phase_in     = PH_TX_LOW;
                        if (!read_dir_ff) begin
                           shift_in = addr_latch_ff;
                        end else if (byte_index_ff == '0) begin
                           shift_in = addr_latch_ff & ADDR_WRITE_MASK;
                        end else begin
                           shift_in = addr_latch_ff | ADDR_READ_BIT;
                        end
                     end
                     PH_TX_LOW: phase_in = PH_TX_HIGH;
                     PH_TX_HIGH: begin
                        shift_in     = {shift_ff[6:0], 1'b0};
                        bit_index_in = bit_index_ff + 4'd1;
                        phase_in     = (bit_index_ff == 4'd7) ? PH_ACK_LOW : PH_TX_LOW;
                     end
                     PH_ACK_LOW: phase_in = PH_ACK_HIGH;
                     PH_ACK_HIGH: begin
                        if (req.sda_in) begin
                           // slave did not acknowledge: abort without stop
                           phase_in = PH_IDLE;
                           nack_err = 1'b1;
                           done     = 1'b1;
                        end else begin
                           byte_index_in = byte_index_ff + BiW'(1);
                           if (byte_index_ff == '0) begin
                              shift_in     = reg_latch_ff;
                              bit_index_in = 4'd0;
                              phase_in     = PH_TX_LOW;
                           end else if (read_dir_ff) begin
                              if (byte_index_ff == BiW'(1)) begin
                                 phase_in = PH_START_A;
                              end else if (count_latch_ff == '0) begin
                                 phase_in = PH_STOP_A;
                              end else begin
                                 byte_index_in = BiW'(RxBase);
                                 shift_in      = 8'd0;
                                 bit_index_in  = 4'd0;
                                 phase_in      = PH_RX_LOW;
                              end
                           end else if (data_ptr < BiW'(count_latch_ff)) begin
                              shift_in     = buf_rd_data;
                              bit_index_in = 4'd0;
                              phase_in     = PH_TX_LOW;
                           end else begin
                              phase_in = PH_STOP_A;
                           end
                        end
                     end
                     PH_RX_LOW: phase_in = PH_RX_HIGH;
                     PH_RX_HIGH: begin
                        shift_in     = {shift_ff[6:0], req.sda_in};
                        bit_index_in = bit_index_ff + 4'd1;
                        if (bit_index_ff == 4'd7) begin
                           rx_valid = 1'b1;
                           rx_byte  = {shift_ff[6:0], req.sda_in};
                           rx_last  = is_last(byte_index_ff, count_latch_ff);
                           phase_in = PH_MACK_LOW;
                        end else begin
                           phase_in = PH_RX_LOW;
                        end
                     end
                     PH_MACK_LOW: phase_in = PH_MACK_HIGH;
                     PH_MACK_HIGH: begin
                        if (is_last(byte_index_ff, count_latch_ff)) begin
                           phase_in = PH_STOP_A;
                        end else begin
                           byte_index_in = byte_index_ff + BiW'(1);
                           shift_in      = 8'd0;
                           bit_index_in  = 4'd0;
                           phase_in      = PH_RX_LOW;
                        end
                     end
                     PH_STOP_A: phase_in = PH_STOP_B;
                     PH_STOP_B: phase_in = PH_STOP_C;
                     PH_STOP_C: begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end else begin
                  interval_in = tick_sum[8:0];
               end
            end
         end else if (phase_ff == PH_IDLE) begin
            if ((req.mode == MODE_WRITE) || (req.mode == MODE_READ)) begin
               // latch the transaction and start
               addr_latch_in = req.device_addr;
               reg_latch_in  = req.register_addr;
               if (32'(req.byte_count) > MaxBytes) begin
                  count_latch_in = CntW'(MaxBytes);
               end else begin
                  count_latch_in = CntW'(req.byte_count);
               end
               read_dir_in   = (req.mode == MODE_READ);
               if (req.mode == MODE_WRITE) begin
                  tx_fill_in = '0;
               end
               byte_index_in = '0;
               bit_index_in  = 4'd0;
               shift_in      = 8'd0;
               interval_in   = 9'd0;
               phase_in      = PH_START_A;
            end else if (buf_wr_en) begin
               tx_fill_in = tx_fill_ff + CntW'(1);
            end
         end
      end
   end

   // line levels and result of the step
   always_comb begin
      rsp            = '0;
      rsp.busy_res   = (phase_in != PH_IDLE);
      rsp.rx_valid   = rx_valid;
      rsp.rx_byte    = rx_byte;
      rsp.rx_last    = rx_last;
      rsp.nack_error = nack_err;
      rsp.done_res   = done;
      case (phase_in)
         PH_START_A:   begin rsp.scl_level = 1'b0; rsp.sda_level = 1'b1; end
         PH_START_B:   begin rsp.scl_level = 1'b1; rsp.sda_level = 1'b1; end
         PH_START_C:   begin rsp.scl_level = 1'b1; rsp.sda_level = 1'b0; end
         PH_START_D:   begin rsp.scl_level = 1'b0; rsp.sda_level = 1'b0; end
         PH_TX_LOW:    begin rsp.scl_level = 1'b0; rsp.sda_level = shift_in[7]; end
         PH_TX_HIGH:   begin rsp.scl_level = 1'b1; rsp.sda_level = shift_in[7]; end
         PH_ACK_LOW:   begin rsp.scl_level = 1'b0; rsp.sda_level = 1'b1; end
         PH_RX_LOW:    begin rsp.scl_level = 1'b0; rsp.sda_level = 1'b1; end
         PH_MACK_LOW:  begin
            rsp.scl_level = 1'b0;
            rsp.sda_level = is_last(byte_index_in, count_latch_in);
         end
         PH_MACK_HIGH: begin
            rsp.scl_level = 1'b1;
            rsp.sda_level = is_last(byte_index_in, count_latch_in);
         end
         PH_STOP_A:    begin rsp.scl_level = 1'b0; rsp.sda_level = 1'b0; end
         PH_STOP_B:    begin rsp.scl_level = 1'b1; rsp.sda_level = 1'b0; end
         default:      begin rsp.scl_level = 1'b1; rsp.sda_level = 1'b1; end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         interval_ff    <= 9'd0;
         bit_index_ff   <= 4'd0;
         byte_index_ff  <= '0;
         shift_ff       <= 8'd0;
         tx_fill_ff     <= '0;
         addr_latch_ff  <= 8'd0;
         reg_latch_ff   <= 8'd0;
         count_latch_ff <= '0;
         read_dir_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         interval_ff    <= interval_in;
         bit_index_ff   <= bit_index_in;
         byte_index_ff  <= byte_index_in;
         shift_ff       <= shift_in;
         tx_fill_ff     <= tx_fill_in;
         addr_latch_ff  <= addr_latch_in;
         reg_latch_ff   <= reg_latch_in;
         count_latch_ff <= count_latch_in;
         read_dir_ff    <= read_dir_in;
      end
   end

endmodule

[design/i2c_master_register_transfer.sv]
// top level of the i2c master register transfer engine
// depends on i2cmrt_pkg, i2cmrt_req_if, i2cmrt_rsp_if, i2cmrt_txbuf, i2cmrt_engine
//
//   channel   dir   handshake          carries
//   req_chan  in    valid / ready      tick, begin write, begin read, load byte
//   rsp_chan  out   valid / ready      line levels, status, received byte
//   csr_*     in    csr_wr_en          half period in ticks (9 bits)
//
// every request is handled in the cycle it is accepted and its response is
// registered, so one transfer per cycle is sustained while the response channel
// is ready; the response register sets that figure
// a request is accepted while the response register is empty or being drained
// synchronous reset puts the sequencer idle and the half period back to 5; no
// clearing pass; user must only read write buffer entries loaded earlier, not enforced

module i2c_master_register_transfer import i2cmrt_pkg::*; #(
   parameter int MaxBytes = MaxBytesDef
) (
   input  logic             clock,
   input  logic             reset,
   i2cmrt_req_if.sink       req_chan,
   i2cmrt_rsp_if.source     rsp_chan,
   input  logic             csr_wr_en,
   input  logic [8:0]       csr_wr_data
);

   localparam int AddrW = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;

   logic [8:0]      half_period_ff, half_period_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            req_accept;
   rsp_payload_type step_rsp;
   logic [7:0]      buf_rd_data;
   logic [AddrW-1:0] buf_rd_addr;
   logic            buf_wr_en;
   logic [AddrW-1:0] buf_wr_addr;
   logic [7:0]      buf_wr_data;

   // request handshake
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // half period register
   assign half_period_in = csr_wr_en ? csr_wr_data : half_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else begin
         half_period_ff <= half_period_in;
      end
   end

   // write data buffer
   i2cmrt_txbuf #(
      .Depth (MaxBytes)
   ) u_txbuf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (buf_wr_data),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   // bus sequencer
   i2cmrt_engine #(
      .MaxBytes (MaxBytes)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .step_en     (req_accept),
      .req         (req_chan.payload),
      .half_period (half_period_ff),
      .buf_rd_data (buf_rd_data),
      .buf_rd_addr (buf_rd_addr),
      .buf_wr_en   (buf_wr_en),
      .buf_wr_addr (buf_wr_addr),
      .buf_wr_data (buf_wr_data),
      .rsp         (step_rsp)
   );

   // response register
   assign rsp_valid_in   = req_accept || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_payload_in = req_accept ? step_rsp : rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule
